[rtl/assert_macros.svh]
// Assertion macros used by the top level of the node-ID allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a property at every rising clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check that a condition is followed by a consequence in the next clock cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/pna_pkg.sv]
// Types, constants and codes shared by the node-ID allocator modules.
`default_nettype none

package pna_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W        = 7;
    localparam int NUM_IDS     = 2 ** ID_W;
    localparam int NEXT_W      = ID_W + 1;
    localparam int KEY_W       = 64;
    localparam int TIME_W      = 64;
    localparam int LEN_W       = 8;
    localparam int XFER_W      = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [NEXT_W-1:0] MAX_NODE_ID   = NEXT_W'(127);
    localparam logic [LEN_W-1:0]  MIN_UID_BYTES = LEN_W'(16);
    localparam logic [FILL_W-1:0] TABLE_FULL    = FILL_W'(TABLE_DEPTH);

    localparam logic [ID_W-1:0]   LOCAL_ID_RST  = ID_W'(0);
    localparam logic [ID_W-1:0]   FIRST_ID_RST  = ID_W'(1);
    localparam logic [TIME_W-1:0] WINDOW_RST    = TIME_W'(3000000);
    localparam logic [TIME_W-1:0] STARTUP_RST   = TIME_W'(0);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOCAL_ID = 2'd0,
        CFG_FIRST_ID = 2'd1,
        CFG_WINDOW   = 2'd2,
        CFG_STARTUP  = 2'd3
    } cfg_idx_t;

    typedef enum logic [0:0] {
        REQ_TICK = 1'b0,
        REQ_MSG  = 1'b1
    } req_type_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_FREE,
        S_WRITE
    } state_t;

    typedef struct packed {
        logic [0:0]        req_type;
        logic [TIME_W-1:0] now_us;
        logic              from_known_node;
        logic [LEN_W-1:0]  payload_len;
        logic [KEY_W-1:0]  uid_low;
        logic [KEY_W-1:0]  uid_high;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0]   node_id;
        logic              exhausted;
        logic [KEY_W-1:0]  resp_uid_low;
        logic [KEY_W-1:0]  resp_uid_high;
        logic [XFER_W-1:0] xfer_id;
    } out_item_t;

    typedef struct packed {
        logic [ID_W-1:0]   own_id;
        logic [ID_W-1:0]   first_dynamic_id;
        logic [TIME_W-1:0] passive_window_us;
        logic [TIME_W-1:0] startup_time_us;
    } cfg_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_ctl_t;

    typedef struct packed {
        logic            set_en;
        logic [ID_W-1:0] set_id;
        logic [ID_W-1:0] query_id;
    } map_ctl_t;

endpackage

`default_nettype wire

[rtl/pna_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/pna_idmap.sv]
// Bitmap of node IDs already handed out, with one set port and one query port.
`default_nettype none

module pna_idmap (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pna_pkg::map_ctl_t  ctl,
    output logic                    used
);

    logic [pna_pkg::NUM_IDS-1:0] used_reg;
    logic [pna_pkg::NUM_IDS-1:0] used_next;

    always_comb
    begin
        used_next = used_reg;
        if (ctl.set_en)
        begin
            used_next[ctl.set_id] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    assign used = used_reg[ctl.query_id];

endmodule

`default_nettype wire

[rtl/pna_seq.sv]
// Sequencer: decodes a transaction, scans the table, searches a free ID, responds.
`default_nettype none

module pna_seq (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire pna_pkg::in_item_t          request,
    input  wire pna_pkg::cfg_t              cfg,
    input  wire logic                       first_load,
    input  wire logic [pna_pkg::ID_W-1:0]   first_id,
    output pna_pkg::out_item_t              result,
    output logic                            done,
    output pna_pkg::ram_ctl_t               ram_ctl,
    output pna_pkg::entry_t                 ram_wdata,
    input  wire pna_pkg::entry_t            ram_rdata,
    output pna_pkg::map_ctl_t               map_ctl,
    input  wire logic                       map_used
);

    pna_pkg::state_t                    state_reg,  state_next;
    pna_pkg::in_item_t                  item_reg,   item_next;
    logic                               active_reg, active_next;
    logic                               rival_reg,  rival_next;
    logic [pna_pkg::NEXT_W-1:0]         next_id_reg, next_id_next;
    logic [pna_pkg::FILL_W-1:0]         fill_reg,   fill_next;
    logic [pna_pkg::FILL_W-1:0]         idx_reg,    idx_next;
    logic [pna_pkg::XFER_W-1:0]         xfer_reg,   xfer_next;
    pna_pkg::out_item_t                 result_reg, result_next;
    logic                               done_reg,   done_next;
    logic [pna_pkg::TIME_W-1:0]         elapsed;

    function automatic pna_pkg::out_item_t make_resp(
        input logic [pna_pkg::ID_W-1:0]   id,
        input logic                       exh,
        input pna_pkg::in_item_t          item,
        input logic [pna_pkg::XFER_W-1:0] xfer
    );
        pna_pkg::out_item_t r;
        r.node_id       = id;
        r.exhausted     = exh;
        r.resp_uid_low  = item.uid_low;
        r.resp_uid_high = item.uid_high;
        r.xfer_id       = xfer;
        return r;
    endfunction

    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        active_next  = active_reg;
        rival_next   = rival_reg;
        next_id_next = next_id_reg;
        fill_next    = fill_reg;
        idx_next     = idx_reg;
        xfer_next    = xfer_reg;
        result_next  = result_reg;
        done_next    = 1'b0;

        ram_ctl          = '0;
        ram_ctl.raddr    = idx_reg[pna_pkg::ADDR_W-1:0];
        ram_ctl.waddr    = fill_reg[pna_pkg::ADDR_W-1:0];
        ram_wdata.key    = item_reg.uid_low;
        ram_wdata.id     = next_id_reg[pna_pkg::ID_W-1:0];
        map_ctl          = '0;
        map_ctl.query_id = next_id_reg[pna_pkg::ID_W-1:0];
        map_ctl.set_id   = next_id_reg[pna_pkg::ID_W-1:0];

        elapsed = item_reg.now_us - cfg.startup_time_us;

        unique case (state_reg)
            pna_pkg::S_IDLE:
            begin
                if (start)
                begin
                    item_next  = request;
                    state_next = pna_pkg::S_DECODE;
                end
            end

            pna_pkg::S_DECODE:
            begin
                state_next = pna_pkg::S_IDLE;
                if (item_reg.req_type == pna_pkg::REQ_TICK)
                begin
                    if (!active_reg && !rival_reg && (elapsed > cfg.passive_window_us))
                    begin
                        active_next = 1'b1;
                    end
                end
                else if (item_reg.from_known_node)
                begin
                    if (!active_reg)
                    begin
                        rival_next = 1'b1;
                    end
                end
                else if (active_reg && (item_reg.payload_len >= pna_pkg::MIN_UID_BYTES))
                begin
                    idx_next   = '0;
                    state_next = pna_pkg::S_SCAN_RD;
                end
            end

            pna_pkg::S_SCAN_RD:
            begin
                if (idx_reg == fill_reg)
                begin
                    if (fill_reg == pna_pkg::TABLE_FULL)
                    begin
                        result_next = make_resp('0, 1'b1, item_reg, xfer_reg);
                        done_next   = 1'b1;
                        xfer_next   = xfer_reg + 1'b1;
                        state_next  = pna_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = pna_pkg::S_FREE;
                    end
                end
                else
                begin
                    ram_ctl.re = 1'b1;
                    state_next = pna_pkg::S_SCAN_CMP;
                end
            end

            pna_pkg::S_SCAN_CMP:
            begin
                if (ram_rdata.key == item_reg.uid_low)
                begin
                    result_next = make_resp(ram_rdata.id, 1'b0, item_reg, xfer_reg);
                    done_next   = 1'b1;
                    xfer_next   = xfer_reg + 1'b1;
                    state_next  = pna_pkg::S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = pna_pkg::S_SCAN_RD;
                end
            end

            pna_pkg::S_FREE:
            begin
                priority if (next_id_reg > pna_pkg::MAX_NODE_ID)
                begin
                    result_next = make_resp('0, 1'b1, item_reg, xfer_reg);
                    done_next   = 1'b1;
                    xfer_next   = xfer_reg + 1'b1;
                    state_next  = pna_pkg::S_IDLE;
                end
                else if ((next_id_reg[pna_pkg::ID_W-1:0] != cfg.own_id) && !map_used)
                begin
                    state_next = pna_pkg::S_WRITE;
                end
                else
                begin
                    next_id_next = next_id_reg + 1'b1;
                end
            end

            pna_pkg::S_WRITE:
            begin
                ram_ctl.we     = 1'b1;
                map_ctl.set_en = 1'b1;
                result_next    = make_resp(next_id_reg[pna_pkg::ID_W-1:0], 1'b0,
                                           item_reg, xfer_reg);
                done_next      = 1'b1;
                xfer_next      = xfer_reg + 1'b1;
                next_id_next   = next_id_reg + 1'b1;
                fill_next      = fill_reg + 1'b1;
                state_next     = pna_pkg::S_IDLE;
            end

            default:
            begin
                state_next = pna_pkg::S_IDLE;
            end
        endcase

        // A write of the first dynamic ID restarts the free search there.
        if (first_load)
        begin
            next_id_next = {1'b0, first_id};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pna_pkg::S_IDLE;
            active_reg  <= 1'b0;
            rival_reg   <= 1'b0;
            next_id_reg <= {1'b0, pna_pkg::FIRST_ID_RST};
            fill_reg    <= '0;
            idx_reg     <= '0;
            xfer_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            rival_reg   <= rival_next;
            next_id_reg <= next_id_next;
            fill_reg    <= fill_next;
            idx_reg     <= idx_next;
            xfer_reg    <= xfer_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != pna_pkg::S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[rtl/pnp_node_id_allocator_top.sv]
// Top level of the plug-and-play node-ID allocator: configuration registers and wiring.
`default_nettype none
`include "assert_macros.svh"

// Plug-and-play node-ID allocator.
// Issue a transaction by raising start while busy is low; the transaction is
// taken at that edge and busy stays high until it is done.
// The block starts passive. A tick (req_type 0) makes it active once
// now_us - startup_time_us (mod 2^64) exceeds passive_window_us, unless a
// message from a known node arrived first. Once active, an anonymous message
// with at least 16 payload bytes is looked up by uid_low. A known key returns
// its stored ID; a new key gets the next free ID up to 127, skipping the local
// ID and every ID already given out. If no ID or no table slot is left, the
// response carries exhausted = 1 and node_id = 0.
// Every response is shown on result for exactly one cycle with done high.
// There is no back-pressure: capture result whenever done is high.
// Sequence, with busy high after the accepting edge: a tick or an ignored
// message passes only through the decode state. A lookup of a key that is
// not in the table runs the decode state, a read and a compare state per
// entry stored, since the table RAM has a registered read, and a read state
// that sees the end of the table; with a full table the exhausted response
// follows right there. A key found in an entry ends in the compare state of
// that entry. A new key then runs the free search, which tries the IDs in
// turn (up to 128 IDs), and a write state, or a state that flags exhausted
// when no ID is left. done is high in the cycle after the last busy cycle,
// with busy already low, so the next transaction can be taken at the edge
// ending it.
// Configuration writes (cfg_we, cfg_idx, cfg_data) take effect at once and
// are only allowed while busy is low. Writing first_dynamic_id also restarts
// the free search at that ID. No clearing pass runs after reset.
module pnp_node_id_allocator_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire pna_pkg::in_item_t               request,
    output pna_pkg::out_item_t                   result,
    output logic                                 done,
    input  wire logic                            cfg_we,
    input  wire logic [pna_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  wire logic [pna_pkg::CFG_DATA_W-1:0]  cfg_data
);

    pna_pkg::cfg_t     cfg_reg, cfg_next;
    logic              first_load;
    pna_pkg::ram_ctl_t ram_ctl;
    pna_pkg::entry_t   ram_wdata;
    pna_pkg::entry_t   ram_rdata;
    pna_pkg::map_ctl_t map_ctl;
    logic              map_used;

    // Decode configuration writes; only the low bits of the data are kept
    // for the 7-bit ID registers.
    always_comb
    begin
        cfg_next   = cfg_reg;
        first_load = 1'b0;
        if (cfg_we)
        begin
            unique case (pna_pkg::cfg_idx_t'(cfg_idx))
                pna_pkg::CFG_LOCAL_ID:
                begin
                    cfg_next.own_id = cfg_data[pna_pkg::ID_W-1:0];
                end
                pna_pkg::CFG_FIRST_ID:
                begin
                    cfg_next.first_dynamic_id = cfg_data[pna_pkg::ID_W-1:0];
                    first_load                = 1'b1;
                end
                pna_pkg::CFG_WINDOW:
                begin
                    cfg_next.passive_window_us = cfg_data[pna_pkg::TIME_W-1:0];
                end
                pna_pkg::CFG_STARTUP:
                begin
                    cfg_next.startup_time_us = cfg_data[pna_pkg::TIME_W-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_id            <= pna_pkg::LOCAL_ID_RST;
            cfg_reg.first_dynamic_id  <= pna_pkg::FIRST_ID_RST;
            cfg_reg.passive_window_us <= pna_pkg::WINDOW_RST;
            cfg_reg.startup_time_us   <= pna_pkg::STARTUP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Sequencer: owns the allocator control state and the response register.
    pna_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .request    (request),
        .cfg        (cfg_reg),
        .first_load (first_load),
        .first_id   (cfg_data[pna_pkg::ID_W-1:0]),
        .result     (result),
        .done       (done),
        .ram_ctl    (ram_ctl),
        .ram_wdata  (ram_wdata),
        .ram_rdata  (ram_rdata),
        .map_ctl    (map_ctl),
        .map_used   (map_used)
    );

    // Key/ID table, filled in slot order.
    pna_ram #(
        .WIDTH (pna_pkg::ENTRY_W),
        .DEPTH (pna_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_ctl.we),
        .waddr (ram_ctl.waddr),
        .wdata (ram_wdata),
        .re    (ram_ctl.re),
        .raddr (ram_ctl.raddr),
        .rdata (ram_rdata)
    );

    // Used-ID bitmap, queried by the free search.
    pna_idmap u_idmap (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (map_ctl),
        .used  (map_used)
    );

    // A response only follows work in progress, and ends it.
    `ASSERT_HOLDS(a_done_after_busy, clk, rst_n, done |-> $past(busy))
    `ASSERT_HOLDS(a_done_idle, clk, rst_n, done |-> !busy)
    // An accepted transaction always makes the block busy in the next cycle.
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    // An exhausted response never carries an ID.
    `ASSERT_HOLDS(a_exh_no_id, clk, rst_n, done && result.exhausted |-> result.node_id == '0)

endmodule

`default_nettype wire

[verif/tb_pnp_node_id_allocator_top.sv]
// Self-checking testbench for the plug-and-play node-ID allocator top level.
module tb_pnp_node_id_allocator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pna_pkg::*;

    // Run-length guard and the quiet pause before any register write or the end.
    // The pause outlasts the longest busy stretch of a request, so it covers
    // a transaction that is still in flight without producing a result.
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int QUIET_CYCLES = 400;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    in_item_t           request = '0;
    out_item_t          result;
    logic               done;
    logic               cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pnp_node_id_allocator_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .result   (result),
        .done     (done),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    // 4 ns clock: low half, then high half.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Allocator state as the testbench predicts it
    // ------------------------------------------------------------------
    logic [ID_W-1:0]   own_id       = LOCAL_ID_RST;
    logic [TIME_W-1:0] window_us    = WINDOW_RST;
    logic [TIME_W-1:0] startup_us   = STARTUP_RST;
    logic              is_active    = 1'b0;
    logic              rival_heard  = 1'b0;
    logic [NEXT_W-1:0] next_free    = {1'b0, FIRST_ID_RST};
    logic [XFER_W-1:0] xfer_seq     = '0;
    logic [KEY_W-1:0]  slot_key  [TABLE_DEPTH];
    logic [ID_W-1:0]   slot_id   [TABLE_DEPTH];
    logic              slot_used [TABLE_DEPTH];

    in_item_t          pending[$];      // transactions waiting to be issued
    out_item_t         grants_due[$];   // responses predicted, not yet seen
    logic [KEY_W-1:0]  uid_pool[$];     // UIDs already offered, for repeat lookups

    int                send_idle_pct = 0;
    int                error_count = 0;
    int                cycle_count = 0;
    logic              item_taken = 1'b0;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Put a 7-bit value in the low bits and random junk above it; the junk must
    // be ignored by the register.
    function automatic logic [63:0] pad_id(input logic [ID_W-1:0] id);
        logic [63:0] v;
        v = rand64();
        v[ID_W-1:0] = id;
        return v;
    endfunction

    function automatic in_item_t make_item(input req_type_t kind, input logic [TIME_W-1:0] now,
                                           input logic known, input logic [LEN_W-1:0] len,
                                           input logic [KEY_W-1:0] lo, input logic [KEY_W-1:0] hi);
        in_item_t it;
        it.req_type        = kind;
        it.now_us          = now;
        it.from_known_node = known;
        it.payload_len     = len;
        it.uid_low         = lo;
        it.uid_high        = hi;
        return it;
    endfunction

    function automatic bit id_taken(input logic [ID_W-1:0] id);
        bit hit;
        int i;
        hit = 0;
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            if (slot_used[i] && slot_id[i] == id)
                hit = 1;
        end
        return hit;
    endfunction

    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        case (idx)
            CFG_LOCAL_ID: own_id = data[ID_W-1:0];
            CFG_FIRST_ID:
            begin
                // Writing the first ID also restarts the free search there.
                next_free = {1'b0, data[ID_W-1:0]};
            end
            CFG_WINDOW:   window_us = data;
            CFG_STARTUP:  startup_us = data;
            default: ;
        endcase
    endtask

    // Advance the predicted state by one transaction and queue the response it
    // causes, if any.
    task automatic predict_allocation(input in_item_t req);
        out_item_t         grant;
        logic [TIME_W-1:0] elapsed;
        logic [ID_W-1:0]   id;
        int                free_slot;
        int                i;
        bit                hit;
        bit                found;
        bit                granted;
        id        = '0;
        free_slot = -1;
        hit       = 0;
        found     = 0;
        granted   = 0;
        elapsed   = req.now_us - startup_us;   // wraps modulo 2^64
        if (req.req_type == REQ_TICK)
        begin
            if (!is_active && !rival_heard && elapsed > window_us)
                is_active = 1'b1;
        end
        else if (req.from_known_node)
        begin
            if (!is_active)
                rival_heard = 1'b1;
        end
        else if (is_active && req.payload_len >= MIN_UID_BYTES)
        begin
            // Look the key up; remember the first empty slot on the way.
            for (i = 0; i < TABLE_DEPTH; i++)
            begin
                if (!hit)
                begin
                    if (slot_used[i])
                    begin
                        if (slot_key[i] == req.uid_low)
                        begin
                            hit = 1;
                            id  = slot_id[i];
                        end
                    end
                    else if (free_slot < 0)
                        free_slot = i;
                end
            end
            if (hit)
                granted = 1;
            else if (free_slot >= 0)
            begin
                while (!found && next_free <= MAX_NODE_ID)
                begin
                    if (next_free[ID_W-1:0] != own_id && !id_taken(next_free[ID_W-1:0]))
                        found = 1;
                    else
                        next_free++;
                end
                if (found)
                begin
                    id = next_free[ID_W-1:0];
                    next_free++;
                    slot_key[free_slot]  = req.uid_low;
                    slot_id[free_slot]   = id;
                    slot_used[free_slot] = 1'b1;
                    granted = 1;
                end
            end
            grant.node_id       = granted ? id : '0;
            grant.exhausted     = !granted;
            grant.resp_uid_low  = req.uid_low;
            grant.resp_uid_high = req.uid_high;
            grant.xfer_id       = xfer_seq;
            xfer_seq++;
            grants_due.push_back(grant);
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        error_count++;
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
    endtask

    // ------------------------------------------------------------------
    // Driver: issue pending transactions on the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_requests
        in_item_t next_req;
        logic     offer;
        next_req = request;
        offer    = start;
        // Hold an offered transaction until the block has taken it; then load the
        // next one, or idle at the chosen rate.
        if (!start || item_taken)
        begin
            offer = 1'b0;
            if (pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_req = pending.pop_front();
                offer    = 1'b1;
            end
        end
        start   <= offer;
        request <= next_req;
    end

    // ------------------------------------------------------------------
    // Monitor: sample on the rising edge, check responses, then predict
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_block
        out_item_t want;
        if (rst_n)
        begin
            if (cfg_we)
                apply_register(cfg_idx, cfg_data);
            // Check first, so a stray response is never matched against the
            // prediction for the transaction taken at this same edge.
            if (done === 1'b1)
            begin
                if (grants_due.size() == 0)
                    flag_mismatch("unexpected response, uid_low", '0, result.resp_uid_low);
                else
                begin
                    want = grants_due.pop_front();
                    if (result.node_id !== want.node_id)
                        flag_mismatch("node_id", 64'(want.node_id), 64'(result.node_id));
                    if (result.exhausted !== want.exhausted)
                        flag_mismatch("exhausted", 64'(want.exhausted),
                                      64'(result.exhausted));
                    if (result.resp_uid_low !== want.resp_uid_low)
                        flag_mismatch("resp_uid_low", want.resp_uid_low, result.resp_uid_low);
                    if (result.resp_uid_high !== want.resp_uid_high)
                        flag_mismatch("resp_uid_high", want.resp_uid_high, result.resp_uid_high);
                    if (result.xfer_id !== want.xfer_id)
                        flag_mismatch("xfer_id", 64'(want.xfer_id), 64'(result.xfer_id));
                end
            end
            if (start && !busy)
                predict_allocation(request);
        end
        item_taken <= rst_n && start && !busy;
    end

    // Stop a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t ns: run limit reached, %0d responses outstanding",
                     $time, grants_due.size());
            $display("pnp_node_id_allocator_top verification failed");
            $finish;
        end
    end

    // Wait until every transaction is issued and answered and the block is idle,
    // then let a transaction without a response run out.
    task automatic settle();
        while (pending.size() != 0 || start)
            @(posedge clk);
        while (grants_due.size() != 0 || busy)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [63:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic push_anon(input logic [LEN_W-1:0] len, input logic [KEY_W-1:0] lo,
                             input logic [KEY_W-1:0] hi);
        pending.push_back(make_item(REQ_MSG, rand64(), 1'b0, len, lo, hi));
    endtask

    // Mostly well-formed requests, with fresh or repeated UIDs, mixed with
    // ticks, messages from other allocators and short payloads.
    task automatic random_traffic(input int count, input int new_pct);
        int               answered;
        int               pick;
        logic [KEY_W-1:0] uid;
        answered = 0;
        while (answered < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                pending.push_back(make_item(REQ_TICK, rand64(), 1'($urandom_range(0, 1)),
                                            LEN_W'($urandom_range(0, 255)),
                                            rand64(), rand64()));
            else if (pick < 14)
                pending.push_back(make_item(REQ_MSG, rand64(), 1'b1,
                                            LEN_W'($urandom_range(0, 255)),
                                            rand64(), rand64()));
            else if (pick < 20)
                push_anon(LEN_W'($urandom_range(0, MIN_UID_BYTES - 1)), rand64(), rand64());
            else
            begin
                if (uid_pool.size() == 0 || $urandom_range(0, 99) < new_pct)
                begin
                    uid = rand64();
                    uid_pool.push_back(uid);
                end
                else
                    uid = uid_pool[$urandom_range(0, uid_pool.size() - 1)];
                push_anon(LEN_W'($urandom_range(MIN_UID_BYTES, 255)), uid, rand64());
                answered++;
            end
        end
        settle();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
            slot_used[i] = 1'b0;

        // Hold reset, then release it on a falling edge.
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 38;

        // Passive: a tick with elapsed time equal to the window must not
        // activate, and anonymous requests are dropped. Messages from another
        // allocator are sent only once active: one seen while passive would lock
        // the block passive for the rest of the run.
        pending.push_back(make_item(REQ_TICK, '0, 1'b0, '0, '0, '0));
        pending.push_back(make_item(REQ_TICK, 64'd3000000, 1'b0, '0, '0, '0));
        push_anon(8'd255, rand64(), rand64());
        push_anon(MIN_UID_BYTES, rand64(), rand64());
        settle();

        // Largest window: even a wrapped, maximal elapsed time stays passive.
        write_reg(CFG_WINDOW, '1);
        write_reg(CFG_STARTUP, 64'd5);
        pending.push_back(make_item(REQ_TICK, 64'd4, 1'b0, '0, '0, '0));
        settle();

        // Zero window, start stamp at the top: elapsed 0 holds, elapsed 1
        // (wrapped) activates.
        write_reg(CFG_WINDOW, '0);
        write_reg(CFG_STARTUP, '1);
        pending.push_back(make_item(REQ_TICK, '1, 1'b0, '0, '0, '0));
        pending.push_back(make_item(REQ_TICK, '0, 1'b0, '0, '0, '0));
        push_anon(LEN_W'(MIN_UID_BYTES - 1), rand64(), rand64());
        push_anon(MIN_UID_BYTES, '0, '1);
        push_anon(8'd255, '1, '0);
        push_anon(MIN_UID_BYTES, '0, rand64());     // repeat key, stored ID back
        pending.push_back(make_item(REQ_MSG, rand64(), 1'b1, 8'd255, rand64(), rand64()));
        pending.push_back(make_item(REQ_TICK, rand64(), 1'b0, '0, '0, '0));
        settle();

        // Free search must step over the local ID.
        write_reg(CFG_LOCAL_ID, pad_id(7'd5));
        write_reg(CFG_FIRST_ID, pad_id(7'd4));
        push_anon(MIN_UID_BYTES, rand64(), rand64());
        push_anon(MIN_UID_BYTES, rand64(), rand64());
        settle();

        // Search from the top ID: one grant, then IDs run out, while a repeat key still gets its stored ID.
        write_reg(CFG_FIRST_ID, pad_id(7'd127));
        push_anon(8'd200, rand64(), rand64());
        push_anon(8'd200, rand64(), rand64());
        push_anon(8'd200, '1, rand64());
        settle();

        // Search from zero with the local ID at the top.
        write_reg(CFG_FIRST_ID, pad_id(7'd0));
        write_reg(CFG_LOCAL_ID, pad_id(7'd127));
        push_anon(MIN_UID_BYTES, rand64(), rand64());
        push_anon(MIN_UID_BYTES, rand64(), rand64());
        settle();

        uid_pool.push_back('0);
        uid_pool.push_back('1);

        // Random traffic. The sender idles at times first, then more often, then never.
        // The settings walk the table from sparse to full, where new keys find
        // no free slot.
        write_reg(CFG_LOCAL_ID, pad_id(7'd0));
        write_reg(CFG_FIRST_ID, pad_id(7'd1));
        random_traffic(160, 15);

        write_reg(CFG_LOCAL_ID, pad_id(7'd64));
        write_reg(CFG_FIRST_ID, pad_id(7'd60));
        random_traffic(160, 15);

        send_idle_pct = 73;
        write_reg(CFG_LOCAL_ID, pad_id(7'd127));
        write_reg(CFG_FIRST_ID, pad_id(7'd0));
        random_traffic(160, 35);

        write_reg(CFG_LOCAL_ID, pad_id(7'd0));
        write_reg(CFG_FIRST_ID, pad_id(7'd0));
        random_traffic(160, 40);

        send_idle_pct = 0;
        write_reg(CFG_WINDOW, rand64());
        write_reg(CFG_STARTUP, rand64());
        write_reg(CFG_LOCAL_ID, pad_id(7'd127));
        write_reg(CFG_FIRST_ID, pad_id(7'd127));
        random_traffic(160, 30);

        write_reg(CFG_LOCAL_ID, pad_id(7'd64));
        write_reg(CFG_FIRST_ID, pad_id(7'd1));
        random_traffic(160, 30);

        if (error_count == 0)
            $display("pnp_node_id_allocator_top verification clean");
        else
            $display("pnp_node_id_allocator_top verification failed");
        $finish;
    end

endmodule
